// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the polyhedral distance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PD3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) else $error(msg);
`define PD3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) else $error(msg);
`else
`define PD3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PD3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/pd3_pkg.sv =====
// Package with types, constants and coefficient helper for the polyhedral distance block.
`default_nettype none
package pd3_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DIST_WIDTH      = 26;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  // Coefficients with 64 fractional bits, truncated.
  localparam logic [63:0] K64_SQ2M1   = 64'h6A09E667F3BCC908;
  localparam logic [63:0] K64_SQ3M1   = 64'hBB67AE8584CAA73B;
  localparam logic [63:0] K64_TWO3    = 64'hAAAAAAAAAAAAAAAA;
  localparam logic [63:0] K64_TWOMSQ2 = 64'h95F619980C4336F7;

  typedef enum logic [1:0] {
    FN_DISDYAKIS  = 2'd0,
    FN_TETRAKIS   = 2'd1,
    FN_TRUNC_OCTA = 2'd2,
    FN_TRIAKIS    = 2'd3
  } pd3_func_t;

  typedef struct packed {
    logic      vld;
    pd3_func_t func;
  } pd3_ctl_t;

  // Rounds a 64-bit fraction to nearest at the given number of fractional bits.
  function automatic logic [63:0] pd3_coef(input logic [63:0] k64, input int frac);
    logic [63:0] t;
    t = (k64 >> (63 - frac)) + 64'd1;
    return t >> 1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pd3_order.sv =====
// Front of the pipeline: absolute coordinate differences, then max, min and sum.
`default_nettype none
`include "assert_macros.svh"
module pd3_order
  import pd3_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pd3_ctl_t                      in_ctl,
  input  wire logic signed [COORD_WIDTH-1:0] sender_x,
  input  wire logic signed [COORD_WIDTH-1:0] sender_y,
  input  wire logic signed [COORD_WIDTH-1:0] sender_z,
  input  wire logic signed [COORD_WIDTH-1:0] receiver_x,
  input  wire logic signed [COORD_WIDTH-1:0] receiver_y,
  input  wire logic signed [COORD_WIDTH-1:0] receiver_z,
  output pd3_ctl_t                           out_ctl,
  output logic [COORD_WIDTH-1:0]             mx,
  output logic [COORD_WIDTH-1:0]             mn,
  output logic [COORD_WIDTH+1:0]             sum
);

  localparam int SW = COORD_WIDTH + 2;

  function automatic logic [COORD_WIDTH-1:0] absdiff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [COORD_WIDTH:0] d;
    logic        [COORD_WIDTH:0] m;
    d = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
    m = d[COORD_WIDTH] ? -d : d;
    return m[COORD_WIDTH-1:0];
  endfunction

  pd3_ctl_t               ctl1_r, ctl2_r;
  logic [COORD_WIDTH-1:0] dx_r, dy_r, dz_r;
  logic [COORD_WIDTH-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic [COORD_WIDTH-1:0] mx_r, mn_r, mx_nxt, mn_nxt;
  logic [SW-1:0]          sum_r, sum_nxt;

  always_comb begin
    dx_nxt = absdiff(sender_x, receiver_x);
    dy_nxt = absdiff(sender_y, receiver_y);
    dz_nxt = absdiff(sender_z, receiver_z);
  end

  always_comb begin
    if (dx_r >= dy_r && dx_r >= dz_r) begin
      mx_nxt = dx_r;
    end else if (dy_r >= dz_r) begin
      mx_nxt = dy_r;
    end else begin
      mx_nxt = dz_r;
    end
    if (dx_r <= dy_r && dx_r <= dz_r) begin
      mn_nxt = dx_r;
    end else if (dy_r <= dz_r) begin
      mn_nxt = dy_r;
    end else begin
      mn_nxt = dz_r;
    end
    sum_nxt = SW'(dx_r) + SW'(dy_r) + SW'(dz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    mx_r  <= mx_nxt;
    mn_r  <= mn_nxt;
    sum_r <= sum_nxt;
  end

  assign out_ctl = ctl2_r;
  assign mx      = mx_r;
  assign mn      = mn_r;
  assign sum     = sum_r;

  `PD3_ASSERT_IMP(a_order_sorted, clk, rst_n, ctl2_r.vld, (mx_r >= mn_r && sum_r >= SW'(mx_r) + SW'(mn_r)), "pd3_order: max, min and sum inconsistent")

endmodule
`default_nettype wire

// ===== hdl/pd3_scale.sv =====
// Middle of the pipeline: operand selection, constant multiply and combination.
`default_nettype none
`include "assert_macros.svh"
module pd3_scale
  import pd3_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pd3_ctl_t                            in_ctl,
  input  wire logic [COORD_WIDTH-1:0]              mx,
  input  wire logic [COORD_WIDTH-1:0]              mn,
  input  wire logic [COORD_WIDTH+1:0]              sum,
  output pd3_ctl_t                                 out_ctl,
  output logic [COORD_WIDTH+FRAC_BITS+1:0]         acc
);

  localparam int OW = COORD_WIDTH + 2;
  localparam int AW = OW + FRAC_BITS;

  localparam logic [FRAC_BITS-1:0] C_A = FRAC_BITS'(pd3_coef(K64_SQ2M1, FRAC_BITS));
  localparam logic [FRAC_BITS-1:0] C_T = FRAC_BITS'(pd3_coef(K64_SQ3M1, FRAC_BITS));
  localparam logic [FRAC_BITS-1:0] C_H = FRAC_BITS'(pd3_coef(K64_TWO3, FRAC_BITS));
  localparam logic [FRAC_BITS-1:0] C_B = FRAC_BITS'(pd3_coef(K64_TWOMSQ2, FRAC_BITS));

  pd3_ctl_t             ctl3_r, ctl4_r, ctl5_r;
  logic [OW-1:0]        op_r, op_nxt, base3_r, base_nxt, base4_r;
  logic [FRAC_BITS-1:0] coef;
  logic [AW-1:0]        prod_r, prod_nxt, base_sh, acc_r, acc_nxt;

  // Stage three: operand and base term per function; the middle value comes out of the sum.
  always_comb begin
    case (in_ctl.func)
      FN_DISDYAKIS: begin
        op_nxt   = sum - OW'(mx) - OW'(mn);
        base_nxt = OW'(mx);
      end
      FN_TETRAKIS: begin
        op_nxt   = sum - OW'(mn) + OW'(mx);
        base_nxt = '0;
      end
      FN_TRUNC_OCTA: begin
        op_nxt   = sum;
        base_nxt = OW'(mx);
      end
      default: begin
        op_nxt   = OW'(mn);
        base_nxt = sum;
      end
    endcase
  end

  // Stage four: one constant-coefficient multiply.
  always_comb begin
    case (ctl3_r.func)
      FN_DISDYAKIS:  coef = C_A;
      FN_TETRAKIS:   coef = C_T;
      FN_TRUNC_OCTA: coef = C_H;
      default:       coef = C_B;
    endcase
    prod_nxt = AW'(op_r) * AW'(coef);
  end

  // Stage five: add, pass the product, take the larger or subtract against the whole-metre term.
  always_comb begin
    base_sh = AW'(base4_r) << FRAC_BITS;
    case (ctl4_r.func)
      FN_DISDYAKIS:  acc_nxt = base_sh + prod_r;
      FN_TETRAKIS:   acc_nxt = prod_r;
      FN_TRUNC_OCTA: acc_nxt = (prod_r > base_sh) ? prod_r : base_sh;
      default:       acc_nxt = base_sh - prod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl3_r <= in_ctl;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    base3_r <= base_nxt;
    prod_r  <= prod_nxt;
    base4_r <= base3_r;
    acc_r   <= acc_nxt;
  end

  assign out_ctl = ctl5_r;
  assign acc     = acc_r;

  `PD3_ASSERT_NXT(a_scale_trunc_floor, clk, rst_n, (ctl4_r.vld && ctl4_r.func == FN_TRUNC_OCTA), (acc_r >= $past(base_sh)), "pd3_scale: truncated octahedron below max term")

endmodule
`default_nettype wire

// ===== hdl/polyhedral_distance_3d.sv =====
// Top level of the polyhedral distance block: pipeline of ordering, scaling and rounding.
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+------------------------------
//  input    | in_func, in_sender_*, in_receiver_*     | beat taken when start & !busy
//  result   | out_distance                            | out_valid strobe, one cycle
//
// A beat may be presented in every cycle; busy never rises because nothing in the
// pipeline can be held back. Each beat passes through two stages in the ordering
// front (differences, then max, min and sum), three in the scaling section (operand
// selection, the constant multiply, combination) and the rounding and saturation
// register here, which raises the strobe and holds the result.
// Reset is synchronous and clears only the valid bits travelling with the data, so
// anything in flight at reset is dropped and no stray strobe follows.
// The receiver cannot stall, so the result register is simply overwritten each cycle.
`default_nettype none
`include "assert_macros.svh"
module polyhedral_distance_3d
  import pd3_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_func,
  input  wire logic signed [COORD_WIDTH-1:0] in_sender_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_sender_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_sender_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_receiver_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_receiver_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_receiver_z,
  output logic                               out_valid,
  output logic [DIST_WIDTH-1:0]              out_distance
);

  // Accumulator width: sum of three differences plus the fractional bits.
  localparam int AW   = COORD_WIDTH + 2 + FRAC_BITS;
  // Width of the rounded integer before saturation.
  localparam int RW   = AW + 1 - FRAC_BITS;
  localparam int CMPW = (RW > DIST_WIDTH) ? RW : DIST_WIDTH;

  pd3_ctl_t               in_ctl, ord_ctl, scl_ctl;
  logic                   accept;
  logic [COORD_WIDTH-1:0] mx, mn;
  logic [COORD_WIDTH+1:0] sum;
  logic [AW-1:0]          acc;
  logic [AW:0]            rnd;
  logic [RW-1:0]          whole;
  logic                   over;
  logic                   out_valid_r;
  logic [DIST_WIDTH-1:0]  out_distance_r, out_distance_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign in_ctl = '{vld: accept, func: pd3_func_t'(in_func)};

  pd3_order #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_order (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (in_ctl),
    .sender_x   (in_sender_x),
    .sender_y   (in_sender_y),
    .sender_z   (in_sender_z),
    .receiver_x (in_receiver_x),
    .receiver_y (in_receiver_y),
    .receiver_z (in_receiver_z),
    .out_ctl    (ord_ctl),
    .mx         (mx),
    .mn         (mn),
    .sum        (sum)
  );

  pd3_scale #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (ord_ctl),
    .mx      (mx),
    .mn      (mn),
    .sum     (sum),
    .out_ctl (scl_ctl),
    .acc     (acc)
  );

  // Round half up to whole metres, then clamp to the width of the result field.
  always_comb begin
    rnd              = (AW+1)'(acc) + ((AW+1)'(1) << (FRAC_BITS - 1));
    whole            = rnd[AW:FRAC_BITS];
    over             = CMPW'(whole) > CMPW'(DIST_MAX);
    out_distance_nxt = over ? DIST_MAX : DIST_WIDTH'(whole);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= scl_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_distance_r <= out_distance_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  `PD3_ASSERT_IMP(a_top_latency, clk, rst_n, accept, ##6 out_valid, "polyhedral_distance_3d: result strobe missing six cycles after a beat")
  `PD3_ASSERT_NXT(a_top_reset_quiet, clk, 1'b1, !rst_n, !out_valid, "polyhedral_distance_3d: strobe right after reset")
  `PD3_ASSERT_NXT(a_top_no_phantom, clk, rst_n, !scl_ctl.vld, !out_valid, "polyhedral_distance_3d: strobe without a beat in flight")

endmodule
`default_nettype wire
